FILE: rtl/adpcm_block_stream_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// ADPCM block decoder assertion macros
// Shared assertion forms for the checker of the block stream decoder.
// ---------------------------------------------------------------------------
`ifndef ADPCM_BLOCK_STREAM_DECODER_CORE_DEFINES_SVH
`define ADPCM_BLOCK_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is applied.
`define ABSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("absd assertion failed");

// Next-cycle implication, switched off while reset is applied.
`define ABSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("absd assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ABSD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("absd assertion failed");

`endif

FILE: rtl/absd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM block decoder package
// Block geometry, fixed-point widths, predictor codes and the request type.
// ---------------------------------------------------------------------------
package absd_pkg;

  localparam int BLOCK_BYTES  = 32;
  localparam int SAMPLE_BYTES = 28;
  localparam int SAMPLE_START = BLOCK_BYTES - SAMPLE_BYTES;
  localparam int POS_W        = $clog2(BLOCK_BYTES);

  localparam int HIST_W = 29;
  localparam int PROD_W = 30;
  localparam int ACC_W  = 32;
  localparam int COEF_W = 13;

  localparam logic [COEF_W-1:0] COEF_0_86 = 13'd3523;
  localparam logic [COEF_W-1:0] COEF_1_8  = 13'd7373;
  localparam logic [COEF_W-1:0] COEF_0_82 = 13'd3359;
  localparam logic [COEF_W-1:0] COEF_1_53 = 13'd6267;

  localparam logic signed [ACC_W-1:0] HIST_MIN = -32'sd134219776;
  localparam logic signed [ACC_W-1:0] HIST_MAX = 32'sd134215680;

  localparam logic [3:0] FILT_NONE = 4'd0;
  localparam logic [3:0] FILT_ONE  = 4'd1;
  localparam logic [3:0] FILT_TWO  = 4'd2;
  localparam logic [3:0] FILT_THREE = 4'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] hdr_l;
    logic [7:0] hdr_r;
    logic       has_samples;
    logic       clear;
    logic       stereo;
    logic       last;
  } absd_req_t;

endpackage

FILE: rtl/absd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM byte channel
// Valid/ready channel that carries one compressed byte and its start flag.
// ---------------------------------------------------------------------------
interface absd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adpcm_byte;
  logic       start_of_stream;

  modport source (output valid, output adpcm_byte, output start_of_stream, input ready);
  modport sink (input valid, input adpcm_byte, input start_of_stream, output ready);
endinterface

FILE: rtl/absd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PCM sample channel
// Valid/ready channel that carries one decoded sample with its tags.
// ---------------------------------------------------------------------------
interface absd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               channel;
  logic               last_of_block;

  modport source (output valid, output pcm_sample, output channel, output last_of_block,
                  input ready);
  modport sink (input valid, input pcm_sample, input channel, input last_of_block,
                output ready);
endinterface

FILE: rtl/absd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM decoder front end
// Tracks the block position, keeps the headers and turns bytes into requests.
// ---------------------------------------------------------------------------
module absd_front (
  input  logic               clk,
  input  logic               rst_n,
  absd_in_if.sink            in_ch,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               push,
  output absd_pkg::absd_req_t push_data,
  input  logic               full
);

  logic                        stereo_r, stereo_nxt;
  logic [absd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]                  hdr_l_r, hdr_l_nxt;
  logic [7:0]                  hdr_r_r, hdr_r_nxt;
  logic [absd_pkg::POS_W-1:0]  pos;
  logic                        accept;
  logic                        last;
  logic                        is_sample;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    pos       = in_ch.start_of_stream ? '0 : pos_r;
    last      = (pos == absd_pkg::POS_W'(absd_pkg::BLOCK_BYTES - 1));
    is_sample = (pos >= absd_pkg::POS_W'(absd_pkg::SAMPLE_START)) &&
                (pos != absd_pkg::POS_W'(0)) && (pos != absd_pkg::POS_W'(1));

    push                  = accept && (is_sample || in_ch.start_of_stream);
    push_data.data        = in_ch.adpcm_byte;
    push_data.hdr_l       = hdr_l_r;
    push_data.hdr_r       = hdr_r_r;
    push_data.has_samples = is_sample;
    push_data.clear       = in_ch.start_of_stream;
    push_data.stereo      = stereo_r;
    push_data.last        = last;

    stereo_nxt = cfg_we ? cfg_wdata : stereo_r;
    pos_nxt    = pos_r;
    hdr_l_nxt  = hdr_l_r;
    hdr_r_nxt  = hdr_r_r;
    if (accept) begin
      pos_nxt = last ? '0 : pos + absd_pkg::POS_W'(1);
      if (pos == absd_pkg::POS_W'(0)) begin
        hdr_l_nxt = in_ch.adpcm_byte;
      end
      if (pos == absd_pkg::POS_W'(1)) begin
        hdr_r_nxt = in_ch.adpcm_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b1;
      pos_r    <= '0;
      hdr_l_r  <= '0;
      hdr_r_r  <= '0;
    end else begin
      stereo_r <= stereo_nxt;
      pos_r    <= pos_nxt;
      hdr_l_r  <= hdr_l_nxt;
      hdr_r_r  <= hdr_r_nxt;
    end
  end

endmodule

FILE: rtl/absd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM decoder request queue
// Small first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module absd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  absd_pkg::absd_req_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output absd_pkg::absd_req_t head
);

  absd_pkg::absd_req_t       mem_r [absd_pkg::Q_DEPTH];
  logic [absd_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [absd_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [absd_pkg::Q_AW:0]   count_r, count_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign full       = (count_r == (absd_pkg::Q_AW + 1)'(absd_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == absd_pkg::Q_AW'(absd_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + absd_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == absd_pkg::Q_AW'(absd_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + absd_pkg::Q_AW'(1);
    end
    count_nxt = count_r + (absd_pkg::Q_AW + 1)'(do_push) - (absd_pkg::Q_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/absd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM decoder back end
// Two-stage predictor pipeline with per-channel history and an output register.
// ---------------------------------------------------------------------------
module absd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  absd_pkg::absd_req_t head,
  output logic                pop,
  absd_out_if.source          out_ch
);

  logic signed [absd_pkg::HIST_W-1:0] h1_r [2];
  logic signed [absd_pkg::HIST_W-1:0] h2_r [2];

  logic                               lane_r, lane_nxt;
  logic                               m_valid_r, m_valid_nxt;
  logic                               m_ch_r;
  logic                               m_last_r;
  logic signed [absd_pkg::HIST_W-1:0] m_term_r;
  logic signed [absd_pkg::PROD_W-1:0] m_p1_r;
  logic signed [absd_pkg::PROD_W-1:0] m_p2_r;
  logic signed [absd_pkg::HIST_W-1:0] m_h1_r;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [15:0]                 out_pcm_r;
  logic                               out_ch_r;
  logic                               out_last_r;

  logic                               a_fire;
  logic                               m_free;
  logic                               issue;
  logic                               skip;
  logic                               do_clear;
  logic [3:0]                         nib;
  logic [7:0]                         hdr;
  logic [absd_pkg::COEF_W-1:0]        c1;
  logic [absd_pkg::COEF_W-1:0]        c2;
  logic signed [absd_pkg::HIST_W-1:0] h1;
  logic signed [absd_pkg::HIST_W-1:0] h2;
  logic signed [15:0]                 t16;
  logic signed [15:0]                 ts;
  logic signed [absd_pkg::HIST_W-1:0] term;
  logic signed [42:0]                 prod1;
  logic signed [42:0]                 prod2;
  logic                               s_last;
  logic signed [absd_pkg::ACC_W-1:0]  acc;
  logic signed [absd_pkg::ACC_W-1:0]  clamped;
  logic signed [absd_pkg::ACC_W-1:0]  adj;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pcm_sample    = out_pcm_r;
  assign out_ch.channel       = out_ch_r;
  assign out_ch.last_of_block = out_last_r;

  always_comb begin
    a_fire   = m_valid_r && (!out_valid_r || out_ch.ready);
    m_free   = !m_valid_r || a_fire;
    issue    = head_valid && head.has_samples && m_free && !(m_valid_r && (m_ch_r == lane_r)) &&
               !(!lane_r && head.clear && m_valid_r);
    skip     = head_valid && !head.has_samples && !(head.clear && m_valid_r);
    do_clear = (issue && !lane_r && head.clear) || (skip && head.clear);
    pop      = skip || (issue && (lane_r || !head.stereo));
    lane_nxt = issue ? (lane_r ? 1'b0 : head.stereo) : lane_r;
    s_last   = lane_r ? head.last : (head.last && !head.stereo);

    nib = lane_r ? head.data[7:4] : head.data[3:0];
    hdr = lane_r ? head.hdr_r : head.hdr_l;
    h1  = do_clear ? '0 : h1_r[lane_r];
    h2  = do_clear ? '0 : h2_r[lane_r];

    case (hdr[7:4])
      absd_pkg::FILT_ONE: begin
        c1 = absd_pkg::COEF_0_86;
        c2 = '0;
      end
      absd_pkg::FILT_TWO: begin
        c1 = absd_pkg::COEF_1_8;
        c2 = absd_pkg::COEF_0_82;
      end
      absd_pkg::FILT_THREE: begin
        c1 = absd_pkg::COEF_1_53;
        c2 = absd_pkg::COEF_0_86;
      end
      default: begin
        c1 = '0;
        c2 = '0;
      end
    endcase

    t16   = {nib, 12'b0};
    ts    = t16 >>> hdr[3:0];
    term  = {ts[15], ts, 12'b0};
    prod1 = 43'(h1) * 43'(signed'({1'b0, c1}));
    prod2 = 43'(h2) * 43'(signed'({1'b0, c2}));

    acc = absd_pkg::ACC_W'(m_term_r) + absd_pkg::ACC_W'(m_p1_r) - absd_pkg::ACC_W'(m_p2_r);
    if (acc < absd_pkg::HIST_MIN) begin
      clamped = absd_pkg::HIST_MIN;
    end else if (acc > absd_pkg::HIST_MAX) begin
      clamped = absd_pkg::HIST_MAX;
    end else begin
      clamped = acc;
    end
    adj = clamped + (clamped[absd_pkg::ACC_W-1] ? 32'sd4095 : 32'sd0);

    m_valid_nxt   = issue ? 1'b1 : (a_fire ? 1'b0 : m_valid_r);
    out_valid_nxt = a_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_ch_r   <= lane_r;
      m_last_r <= s_last;
      m_term_r <= term;
      m_p1_r   <= prod1[41:12];
      m_p2_r   <= prod2[41:12];
      m_h1_r   <= h1;
    end
    if (a_fire) begin
      out_pcm_r  <= adj[27:12];
      out_ch_r   <= m_ch_r;
      out_last_r <= m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r      <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      h1_r[0]     <= '0;
      h1_r[1]     <= '0;
      h2_r[0]     <= '0;
      h2_r[1]     <= '0;
    end else begin
      lane_r      <= lane_nxt;
      m_valid_r   <= m_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_clear) begin
        h1_r[0] <= '0;
        h1_r[1] <= '0;
        h2_r[0] <= '0;
        h2_r[1] <= '0;
      end else if (a_fire) begin
        h1_r[m_ch_r] <= absd_pkg::HIST_W'(clamped);
        h2_r[m_ch_r] <= m_h1_r;
      end
    end
  end

endmodule

FILE: rtl/adpcm_block_stream_decoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM block stream decoder
// Decodes 4-bit stereo or mono ADPCM blocks into signed 16-bit PCM samples.
// ---------------------------------------------------------------------------
// Bytes enter on in_ch and samples leave on out_ch, left before right. The
// front end takes one byte per cycle while the two-entry queue has room;
// header and ignored bytes reach the back end only when they carry the
// start flag. The back end is a two-stage pipeline (multiply, then
// accumulate, clamp and history write-back) that issues one sample per
// cycle when left and right alternate and the output accepts. In mono a
// left sample waits until the previous one has written its history. A byte
// with the start flag is held until the multiply stage is empty. The first
// sample of a byte passes through the queue, the multiply stage register
// and the output register.
// ---------------------------------------------------------------------------
module adpcm_block_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  absd_in_if.sink     in_ch,
  absd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic                push;
  absd_pkg::absd_req_t push_data;
  logic                full;
  logic                pop;
  logic                head_valid;
  absd_pkg::absd_req_t head;

  absd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  absd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  absd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: rtl/absd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM decoder port checker
// Watches the top-level ports of the decoder and flags illegal behaviour.
// ---------------------------------------------------------------------------
`include "adpcm_block_stream_decoder_core_defines.svh"

module absd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        cfg_wdata,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pcm_sample,
  input logic        out_channel,
  input logic        out_last_of_block
);

  logic stereo_r;
  logic out_req;

  assign out_req = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      stereo_r <= cfg_wdata;
    end
  end

  `ABSD_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)
  `ABSD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_pcm_sample))
  `ABSD_ASSERT_IMP(a_right_stereo, out_req && out_channel, stereo_r)
  `ABSD_ASSERT_IMP(a_left_last_mono, out_req && !out_channel && out_last_of_block, !stereo_r)

endmodule

bind adpcm_block_stream_decoder_core absd_checker u_absd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_we            (cfg_we),
  .cfg_wdata         (cfg_wdata),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_pcm_sample    (out_ch.pcm_sample),
  .out_channel       (out_ch.channel),
  .out_last_of_block (out_ch.last_of_block)
);

FILE: verif/adpcm_block_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ADPCM block stream decoder testbench
// Feeds directed and random byte streams through the decoder in stereo and
// mono settings. A scoreboard predicts every PCM sample in Q.12 fixed point
// and checks each returned sample in order. Both channels idle at random,
// and the output holds off once for a long stretch.
// ---------------------------------------------------------------------------

typedef struct {
  logic signed [15:0] pcm;
  logic               chan;
  logic               last;
} pcm_sample_t;

class absd_sample_scoreboard;
  bit                 stereo;
  int unsigned        pos;
  logic [7:0]         hdr [2];
  logic signed [28:0] hist_one [2];
  logic signed [28:0] hist_two [2];
  pcm_sample_t        expected [$];
  int                 errors;
  int                 reported;
  int                 bytes_noted;
  int                 samples_checked;

  function new();
    stereo = 1'b1;
    pos = 0;
    for (int c = 0; c < 2; c++) begin
      hdr[c] = '0;
      hist_one[c] = '0;
      hist_two[c] = '0;
    end
    errors = 0;
    reported = 0;
    bytes_noted = 0;
    samples_checked = 0;
  endfunction

  function automatic longint coef_product(longint h, longint c);
    return (h * c) >>> 12;
  endfunction

  function automatic logic signed [15:0] decode_nibble(logic [3:0] nib, int c);
    longint n;
    longint acc;
    longint h1v;
    longint h2v;
    longint lo;
    longint hi;
    longint sample;
    n = $signed(nib);
    h1v = hist_one[c];
    h2v = hist_two[c];
    lo = absd_pkg::HIST_MIN;
    hi = absd_pkg::HIST_MAX;
    acc = ((n * 4096) >>> hdr[c][3:0]) * 4096;
    case (hdr[c][7:4])
      absd_pkg::FILT_ONE: begin
        acc += coef_product(h1v, absd_pkg::COEF_0_86);
      end
      absd_pkg::FILT_TWO: begin
        acc += coef_product(h1v, absd_pkg::COEF_1_8) - coef_product(h2v, absd_pkg::COEF_0_82);
      end
      absd_pkg::FILT_THREE: begin
        acc += coef_product(h1v, absd_pkg::COEF_1_53) - coef_product(h2v, absd_pkg::COEF_0_86);
      end
      default: begin
      end
    endcase
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    hist_two[c] = hist_one[c];
    hist_one[c] = acc[28:0];
    sample = acc / 4096;
    return sample[15:0];
  endfunction

  function void note_byte(logic [7:0] b, logic sos);
    int unsigned p;
    logic        last;
    pcm_sample_t s;
    bytes_noted++;
    if (sos) begin
      for (int c = 0; c < 2; c++) begin
        hist_one[c] = '0;
        hist_two[c] = '0;
      end
      pos = 0;
    end
    p = pos;
    last = (p == absd_pkg::BLOCK_BYTES - 1);
    if (p == 0) begin
      hdr[0] = b;
    end else if (p == 1) begin
      hdr[1] = b;
    end else if (p >= absd_pkg::SAMPLE_START) begin
      s.pcm = decode_nibble(b[3:0], 0);
      s.chan = 1'b0;
      s.last = last && !stereo;
      expected.push_back(s);
      if (stereo) begin
        s.pcm = decode_nibble(b[7:4], 1);
        s.chan = 1'b1;
        s.last = last;
        expected.push_back(s);
      end
    end
    pos = (p + 1 >= absd_pkg::BLOCK_BYTES) ? 0 : p + 1;
  endfunction

  function void check_sample(logic signed [15:0] pcm, logic chan, logic last);
    pcm_sample_t s;
    samples_checked++;
    if (expected.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("Unexpected sample: pcm %0d channel %0b last %0b", pcm, chan, last);
      end
      return;
    end
    s = expected.pop_front();
    if (pcm !== s.pcm || chan !== s.chan || last !== s.last) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("Sample mismatch: expected pcm %0d channel %0b last %0b,", s.pcm, s.chan,
                 s.last);
        $display("  got pcm %0d channel %0b last %0b", pcm, chan, last);
      end
    end
  endfunction

  function int pending();
    return expected.size();
  endfunction
endclass

module adpcm_block_stream_decoder_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 357;
  localparam int N_DIRECTED = 23;
  // Each entry is {start flag, byte}.
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    9'h120, 9'h030, 9'h000, 9'h0FF, 9'h077, 9'h077, 9'h077, 9'h088, 9'h088, 9'h088,
    9'h11F, 9'h0C5, 9'h05A, 9'h0C3, 9'h087, 9'h078, 9'h0F0,
    9'h10A, 9'h004, 9'h069, 9'h096, 9'h00F, 9'h080
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   cycle_count;
  bit   send_burst;
  int   send_run;
  int   mono_phases;
  int   stereo_phases;

  absd_sample_scoreboard sb;

  absd_in_if  in_ch ();
  absd_out_if out_ch ();

  adpcm_block_stream_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_byte(in_ch.adpcm_byte, in_ch.start_of_stream);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_sample(out_ch.pcm_sample, out_ch.channel, out_ch.last_of_block);
    end
  end

  // Output side: random stalls, bursts without stalls, and one long hold-off.
  initial begin
    int  gap;
    int  taken;
    int  run;
    bit  burst;
    taken = 0;
    run = 0;
    burst = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (run == 0) begin
        burst = ($urandom_range(0, 2) == 0);
        run = $urandom_range(20, 80);
      end
      run--;
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      taken++;
      if (taken == HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  // Starts and ends at a falling edge; valid stays high for the next request.
  task automatic send_byte(input logic [7:0] b, input logic sos);
    int gap;
    if (send_run == 0) begin
      send_burst = ($urandom_range(0, 2) == 0);
      send_run = $urandom_range(20, 80);
    end
    send_run--;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adpcm_byte <= b;
    in_ch.start_of_stream <= sos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_stereo(input bit value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.stereo = value;
    if (value) stereo_phases++;
    else mono_phases++;
  endtask

  function automatic logic [7:0] random_header();
    logic [3:0] filt;
    filt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 3));
    return {filt, 4'($urandom_range(0, 15))};
  endfunction

  // Mostly whole blocks that open a fresh stream now and then; some blocks are
  // cut short, and a rare start flag lands in the middle of a block.
  task automatic send_stream(input int n_items);
    int         sent;
    int         len;
    bit         fresh;
    logic [7:0] b;
    logic       sos;
    sent = 0;
    fresh = 1'b1;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, absd_pkg::BLOCK_BYTES - 1) :
            absd_pkg::BLOCK_BYTES;
      for (int k = 0; k < len; k++) begin
        if (k < 2) b = random_header();
        else b = 8'($urandom_range(0, 255));
        sos = (k == 0 && fresh) || ($urandom_range(0, 299) == 0);
        send_byte(b, sos);
        sent++;
      end
      fresh = (len != absd_pkg::BLOCK_BYTES) || ($urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    send_burst = 1'b0;
    send_run = 0;
    mono_phases = 0;
    stereo_phases = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adpcm_byte = 8'h00;
    in_ch.start_of_stream = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    end
    drain_and_settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_stereo(ph[0]);
      send_stream(PHASE_ITEMS);
      drain_and_settle();
    end

    $display("Run covered %0d byte requests and %0d samples checked,", sb.bytes_noted,
             sb.samples_checked);
    $display("over %0d stereo and %0d mono phases, with one long output hold-off.",
             stereo_phases, mono_phases);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
